// ----- rtl/atmr_pkg.sv -----
`default_nettype none

package atmr_pkg;

  localparam int unsigned TIME_W  = 12;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned COUNT_W = 5;

  // func codes
  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // decimal HHMM: hour weight
  localparam logic [TIME_W-1:0] DECIMAL_SPLIT = 12'd100;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] alarm_hhmm;
    logic [HOUR_W-1:0] now_hour;
    logic [MIN_W-1:0]  now_minute;
  } in_t;

  typedef struct packed {
    logic               ring;
    logic               add_rejected;
    logic [COUNT_W-1:0] alarm_count;
  } out_t;

endpackage

`default_nettype wire

// ----- rtl/alarm_table_match_remove.sv -----
// Alarm table with match-and-remove. An add item goes from acceptance to the
// done state, which loads its result into the output register. A tick item
// walks the table one entry per cycle through a single memory read port and
// one 12-bit equality compare; the read data is registered before the
// compare, and the done state then loads the output register. The
// tick's hour and minute are folded once into an HHMM value, so each entry is
// matched with a plain compare. Kept entries are written back in place behind
// the read pointer. One item is in work at a time; the finished result sits
// in an output register, and a new item may be accepted while it waits.
`default_nettype none

module alarm_table_match_remove
  import atmr_pkg::*;
#(
  parameter int unsigned MAX_ALARMS = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  localparam int unsigned IdxW = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
  localparam int unsigned CntW = $clog2(MAX_ALARMS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ALARMS);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StDone
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   count_q;
  logic [CntW-1:0]   rd_cnt_q;
  logic [CntW-1:0]   kept_q;
  logic              pend_q;
  logic [TIME_W-1:0] target_q;
  logic              ring_q;
  logic              rej_q;
  logic              out_valid_q;
  out_t              out_q;

  logic [TIME_W-1:0] mem_q [MAX_ALARMS];
  logic [TIME_W-1:0] rdata_q;

  logic              accept;
  logic              issue;
  logic              hit;
  logic              we;
  logic [IdxW-1:0]   waddr;
  logic [TIME_W-1:0] wdata;
  logic [CntW+4:0]   count_ext;

  assign in_ready_o  = (state_q == StIdle);
  assign accept      = in_valid_i && in_ready_o;
  assign issue       = (state_q == StScan) && (rd_cnt_q < count_q);
  assign hit         = (rdata_q == target_q);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign count_ext   = {5'b0, count_q};

  // single write port: append on add, compaction during a scan
  always_comb begin
    we    = 1'b0;
    waddr = kept_q[IdxW-1:0];
    wdata = rdata_q;
    if (accept && in_i.func == FUNC_ADD && count_q < MaxCnt) begin
      we    = 1'b1;
      waddr = count_q[IdxW-1:0];
      wdata = in_i.alarm_hhmm;
    end else if (state_q == StScan && pend_q && !hit) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (issue) begin
      rdata_q <= mem_q[rd_cnt_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      kept_q      <= '0;
      pend_q      <= 1'b0;
      target_q    <= '0;
      ring_q      <= 1'b0;
      rej_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // StDone reloads the output register itself
      if (out_valid_q && out_ready_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            ring_q   <= 1'b0;
            rej_q    <= 1'b0;
            rd_cnt_q <= '0;
            kept_q   <= '0;
            pend_q   <= 1'b0;
            target_q <= TIME_W'(in_i.now_hour) * DECIMAL_SPLIT
                        + TIME_W'(in_i.now_minute);
            if (in_i.func == FUNC_TICK) begin
              state_q <= StScan;
            end else begin
              if (count_q < MaxCnt) begin
                count_q <= count_q + CntW'(1);
              end else begin
                rej_q <= 1'b1;
              end
              state_q <= StDone;
            end
          end
        end
        StScan: begin
          pend_q <= issue;
          if (issue) begin
            rd_cnt_q <= rd_cnt_q + CntW'(1);
          end
          if (pend_q) begin
            if (hit) begin
              ring_q <= 1'b1;
            end else begin
              kept_q <= kept_q + CntW'(1);
            end
          end else if (!issue) begin
            count_q <= kept_q;
            state_q <= StDone;
          end
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.ring         <= ring_q;
            out_q.add_rejected <= rej_q;
            out_q.alarm_count  <= count_ext[COUNT_W-1:0];
            state_q           <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("alarm count above table size");

  a_kept_behind_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> kept_q <= rd_cnt_q && rd_cnt_q <= count_q)
    else $error("compaction pointer ahead of read pointer");

  a_ring_rej_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_o.ring && out_o.add_rejected))
    else $error("ring and add_rejected both set");

  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q && state_q != StScan |-> $past(state_q) == StScan)
    else $error("read pending outside a scan");

  a_count_hold_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan && $past(state_q) == StScan |-> $stable(count_q))
    else $error("count changed in the middle of a scan");

endmodule

`default_nettype wire

// ----- tb/tb_alarm_table_match_remove.sv -----
`timescale 1ns / 1ps

module tb_alarm_table_match_remove;
  import atmr_pkg::*;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned HOUR_WEIGHT = 100;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned CYCLE_LIMIT = 500000;

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid  = 1'b0;
  in_t  drive_item = '0;
  logic in_ready;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_item;

  alarm_table_match_remove #(
    .MAX_ALARMS(TABLE_DEPTH)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_i       (drive_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_o      (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // alarm table as the block should hold it
  logic [TIME_W-1:0] alarm_slots [TABLE_DEPTH];
  int unsigned       alarms_held = 0;

  in_t  pending_items [$];
  out_t expected_results [$];
  bit   added_times [int];

  int unsigned queued_total   = 0;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_idle_pct  = 0;
  int unsigned stall_requests = 0;
  int unsigned stall_served   = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  function automatic out_t predict_alarm(input in_t item);
    out_t              res;
    int unsigned       kept;
    logic [TIME_W-1:0] v;
    res = '0;
    if (item.func == FUNC_ADD) begin
      if (alarms_held < TABLE_DEPTH) begin
        alarm_slots[alarms_held] = item.alarm_hhmm;
        alarms_held++;
      end else begin
        res.add_rejected = 1'b1;
      end
    end else begin
      kept = 0;
      for (int i = 0; i < alarms_held; i++) begin
        v = alarm_slots[i];
        if ((v / HOUR_WEIGHT) == item.now_hour && (v % HOUR_WEIGHT) == item.now_minute) begin
          res.ring = 1'b1;
        end else begin
          alarm_slots[kept] = v;
          kept++;
        end
      end
      alarms_held = kept;
    end
    res.alarm_count = alarms_held[COUNT_W-1:0];
    return res;
  endfunction

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      drive_item <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_alarm(drive_item));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_item <= pending_items.pop_front();
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_mismatch(input string what, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: ring exp %0d got %0d, rejected exp %0d got %0d, count exp %0d got %0d",
               $realtime, what, want.ring, got.ring, want.add_rejected, got.add_rejected,
               want.alarm_count, got.alarm_count);
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing pending", '0, got);
    end else begin
      want = expected_results.pop_front();
      if (got.ring !== want.ring || got.add_rejected !== want.add_rejected ||
          got.alarm_count !== want.alarm_count) begin
        report_mismatch("result mismatch", want, got);
      end
    end
  endtask

  // monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_result(out_item);
      end
      if (stall_served != stall_requests) begin
        stall_served = stall_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void queue_add(input logic [TIME_W-1:0] t);
    in_t it;
    it.func       = FUNC_ADD;
    it.alarm_hhmm = t;
    it.now_hour   = HOUR_W'($urandom);
    it.now_minute = MIN_W'($urandom);
    pending_items.push_back(it);
    added_times[int'(t)] = 1'b1;
    queued_total++;
  endfunction

  function automatic void queue_tick(input logic [HOUR_W-1:0] h, input logic [MIN_W-1:0] m);
    in_t it;
    it.func       = FUNC_TICK;
    it.alarm_hhmm = TIME_W'($urandom);
    it.now_hour   = h;
    it.now_minute = m;
    pending_items.push_back(it);
    queued_total++;
  endfunction

  function automatic void queue_tick_at(input int t);
    queue_tick(HOUR_W'(t / HOUR_WEIGHT), MIN_W'(t % HOUR_WEIGHT));
  endfunction

  // mostly real clock times, sometimes odd ones that a tick can still hit
  function automatic logic [TIME_W-1:0] rand_time();
    if ($urandom_range(9) == 0)
      return TIME_W'($urandom_range(31) * HOUR_WEIGHT + $urandom_range(63));
    return TIME_W'($urandom_range(23) * HOUR_WEIGHT + $urandom_range(59));
  endfunction

  // tick on every time added lately that a tick can hit, so leftovers don't clog the table
  function automatic void flush_added();
    foreach (added_times[t]) begin
      if (t / HOUR_WEIGHT <= 31 && t % HOUR_WEIGHT <= 63) queue_tick_at(t);
    end
    added_times.delete();
  endfunction

  task automatic random_phase(input int unsigned count);
    int unsigned       start;
    int unsigned       kind;
    int unsigned       pool_n;
    logic [TIME_W-1:0] pool [4];
    start = queued_total;
    while (queued_total - start < count) begin
      kind = $urandom_range(99);
      if (kind < 70) begin
        pool_n = $urandom_range(1, 4);
        for (int i = 0; i < 4; i++) pool[i] = rand_time();
        repeat ($urandom_range(1, 8)) queue_add(pool[$urandom_range(pool_n - 1)]);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(99) < 85)
            queue_tick_at(int'(pool[$urandom_range(pool_n - 1)]));
          else
            queue_tick(HOUR_W'($urandom), MIN_W'($urandom));
        end
      end else if (kind < 80) begin
        // overfill the table
        repeat ($urandom_range(10, 20)) queue_add(rand_time());
      end else begin
        if ($urandom_range(1) == 0)
          queue_add(rand_time());
        else
          queue_tick(HOUR_W'($urandom), MIN_W'($urandom));
      end
      if (added_times.num() > 12) flush_added();
    end
    flush_added();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // tick on an empty table, then fill it with edge times and duplicates
    queue_tick(0, 0);
    queue_add(0);
    queue_add(2359);
    queue_add(2359);
    queue_add(4095);
    queue_add(2460);
    queue_add(3163);
    queue_add(1230);
    queue_add(1230);
    queue_add(1230);
    queue_add(59);
    queue_add(1200);
    queue_add(2300);
    queue_add(1);
    queue_add(100);
    queue_add(715);
    queue_add(1845);
    queue_add(999);   // table full: dropped
    queue_tick(23, 59);
    queue_tick(24, 60);
    queue_tick(31, 63);
    queue_tick(0, 0);
    queue_tick(12, 30);
    queue_tick(5, 5);
    wait_drained();

    set_idling(6, 74);
    stall_requests++;
    random_phase(475);
    wait_drained();

    set_idling(74, 6);
    random_phase(475);
    wait_drained();

    set_idling(0, 0);
    stall_requests++;
    random_phase(475);
    wait_drained();

    repeat (50) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
